### rtl/irrigation_light_controller_macros.svh
// ---------------------------------------------------------------------------
// Irrigation light controller assertion macros
// Shared concurrent assertion forms for the controller RTL.
// ---------------------------------------------------------------------------
`ifndef IRRIGATION_LIGHT_CONTROLLER_MACROS_SVH
`define IRRIGATION_LIGHT_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ILC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define ILC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ilc_pkg.sv
// ---------------------------------------------------------------------------
// Irrigation light controller package
// Widths, register defaults, register indexes and shared structs.
// ---------------------------------------------------------------------------
package ilc_pkg;

  // Field widths
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned RAW_W      = 10;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned SEC_W      = 8;
  localparam int unsigned SOD_W      = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Second-of-day split: 86400 = 675 * 128, so the low 7 bits pass through
  localparam int unsigned SOD_LSB_W  = 7;
  localparam int unsigned DAYQ_W     = 16;               // quotient of now / 86400
  localparam int unsigned DAYN_W     = NOW_W - SOD_LSB_W; // 25-bit dividend
  localparam logic [9:0]  DAY_UNITS  = 10'd675;
  // ceil(2^35 / 675): exact floor division for any 25-bit dividend
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam int unsigned DAY_SHIFT  = 35;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE            = 3'd0,
    CFG_MIN_MOISTURE      = 3'd1,
    CFG_TARGET_MOISTURE   = 3'd2,
    CFG_WATERING_DURATION = 3'd3,
    CFG_WATERING_PAUSE    = 3'd4,
    CFG_LIGHT_INTENSITY   = 3'd5,
    CFG_SUNRISE_SECOND    = 3'd6,
    CFG_SUNSET_SECOND     = 3'd7
  } cfg_idx_t;

  // Register file contents
  typedef struct packed {
    logic               enable;
    logic [PCT_W-1:0]   min_moisture;
    logic [PCT_W-1:0]   target_moisture;
    logic [SEC_W-1:0]   watering_duration;
    logic [SEC_W-1:0]   watering_pause;
    logic [LEVEL_W-1:0] light_intensity;
    logic [SOD_W-1:0]   sunrise_second;
    logic [SOD_W-1:0]   sunset_second;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:            1'b1,
    min_moisture:      7'd20,
    target_moisture:   7'd80,
    watering_duration: 8'd10,
    watering_pause:    8'd60,
    light_intensity:   8'd255,
    sunrise_second:    17'd28000,
    sunset_second:     17'd72000
  };

  // Pipeline register load strobes
  typedef struct packed {
    logic load_in;
    logic load_s1;
    logic load_s2;
    logic load_out;
  } pipe_ctrl_t;

  // Stage 2 payload handed to the pump controller
  typedef struct packed {
    logic [NOW_W-1:0] now;
    logic [PCT_W-1:0] moisture;
    logic             reservoir_ok;
    logic             daytime;
  } s2_t;

endpackage

### rtl/ilc_if.sv
// ---------------------------------------------------------------------------
// Irrigation light controller channel interfaces
// Valid/ready channels for tick input, result output and register writes.
// ---------------------------------------------------------------------------

// Tick input channel
interface ilc_in_if;
  logic                        valid;
  logic                        ready;
  logic [ilc_pkg::NOW_W-1:0]   now_seconds;
  logic [ilc_pkg::RAW_W-1:0]   moisture_raw;
  logic                        reservoir_ok;

  modport source (output valid, now_seconds, moisture_raw, reservoir_ok, input ready);
  modport sink   (input valid, now_seconds, moisture_raw, reservoir_ok, output ready);
endinterface

// Result channel
interface ilc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ilc_pkg::LEVEL_W-1:0] light_level;
  logic                        pump_on;
  logic [ilc_pkg::PCT_W-1:0]   moisture_percent;

  modport source (output valid, light_level, pump_on, moisture_percent, input ready);
  modport sink   (input valid, light_level, pump_on, moisture_percent, output ready);
endinterface

// Register write channel
interface ilc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ilc_pkg::CFG_IDX_W-1:0]  index;
  logic [ilc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/ilc_front.sv
// ---------------------------------------------------------------------------
// Irrigation light controller front pipeline
// Input register, day-quotient and moisture stage, second-of-day stage.
// ---------------------------------------------------------------------------
`include "irrigation_light_controller_macros.svh"

module ilc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ilc_pkg::pipe_ctrl_t             ctrl,
  input  logic [ilc_pkg::NOW_W-1:0]       now_i,
  input  logic [ilc_pkg::RAW_W-1:0]       raw_i,
  input  logic                            ok_i,
  input  logic [ilc_pkg::SOD_W-1:0]       sunrise_i,
  input  logic [ilc_pkg::SOD_W-1:0]       sunset_i,
  output ilc_pkg::s2_t                    s2_o
);

  // Input register
  logic [ilc_pkg::NOW_W-1:0]  in_now_r;
  logic [ilc_pkg::RAW_W-1:0]  in_raw_r;
  logic                       in_ok_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      in_now_r <= now_i;
      in_raw_r <= raw_i;
      in_ok_r  <= ok_i;
    end
  end

  // Stage 1: quotient of (now >> 7) / 675 by reciprocal multiply
  logic [ilc_pkg::DAYN_W-1:0] day_n;
  logic [50:0]                q_prod;
  logic [ilc_pkg::DAYQ_W-1:0] q_nxt;

  assign day_n  = in_now_r[ilc_pkg::NOW_W-1:ilc_pkg::SOD_LSB_W];
  assign q_prod = {26'd0, day_n} * {25'd0, ilc_pkg::DAY_RECIP};
  assign q_nxt  = q_prod[ilc_pkg::DAY_SHIFT +: ilc_pkg::DAYQ_W];

  // Stage 1: moisture = (1023 - raw) * 100 / 1023
  // floor(x / 1023) == ((x + 1) * 1025) >> 20 for x up to 102300
  logic [9:0]               dry;
  logic [16:0]              pct_x;
  logic [16:0]              pct_y;
  logic [26:0]              pct_z;
  logic [ilc_pkg::PCT_W-1:0] moist_nxt;

  assign dry       = 10'd1023 - in_raw_r;
  assign pct_x     = {1'b0, dry, 6'd0} + {2'b0, dry, 5'd0} + {5'd0, dry, 2'd0};
  assign pct_y     = pct_x + 17'd1;
  assign pct_z     = {10'd0, pct_y} + {pct_y, 10'd0};
  assign moist_nxt = pct_z[26:20];

  logic [ilc_pkg::NOW_W-1:0]  s1_now_r;
  logic [ilc_pkg::DAYQ_W-1:0] s1_q_r;
  logic [ilc_pkg::PCT_W-1:0]  s1_moist_r;
  logic                       s1_ok_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_s1) begin
      s1_now_r   <= in_now_r;
      s1_q_r     <= q_nxt;
      s1_moist_r <= moist_nxt;
      s1_ok_r    <= in_ok_r;
    end
  end

  // Stage 2: remainder, second of day and daylight window
  logic [25:0]              qm;
  logic [ilc_pkg::DAYN_W-1:0] rem_full;
  logic [10:0]              rem_est;
  logic [10:0]              rem;
  logic [ilc_pkg::SOD_W-1:0] sod;
  ilc_pkg::s2_t             s2_nxt;

  assign qm       = {10'd0, s1_q_r} * {16'd0, ilc_pkg::DAY_UNITS};
  assign rem_full = s1_now_r[ilc_pkg::NOW_W-1:ilc_pkg::SOD_LSB_W] - qm[ilc_pkg::DAYN_W-1:0];
  assign rem_est  = rem_full[10:0];
  // one correction step in case the estimate runs short by one
  assign rem      = (rem_est >= {1'b0, ilc_pkg::DAY_UNITS}) ?
                    (rem_est - {1'b0, ilc_pkg::DAY_UNITS}) : rem_est;
  assign sod      = {rem[9:0], s1_now_r[ilc_pkg::SOD_LSB_W-1:0]};

  always_comb begin
    s2_nxt.now          = s1_now_r;
    s2_nxt.moisture     = s1_moist_r;
    s2_nxt.reservoir_ok = s1_ok_r;
    s2_nxt.daytime      = (sod > sunrise_i) && (sod < sunset_i);
  end

  ilc_pkg::s2_t s2_r;

  always_ff @(posedge clk) begin
    if (ctrl.load_s2) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_o = s2_r;

  // Checks
  `ILC_ASSERT_NXT(a_moist_range, clk, rst_n, ctrl.load_s1, s1_moist_r <= 7'd100, "moisture above 100 percent")
  `ILC_ASSERT_IMP(a_rem_range, clk, rst_n, ctrl.load_s2, rem < {1'b0, ilc_pkg::DAY_UNITS}, "second-of-day remainder out of range")

endmodule

### rtl/ilc_pump_ctrl.sv
// ---------------------------------------------------------------------------
// Irrigation light controller pump and light stage
// Pump state update, stop/start time keeping and the result register.
// ---------------------------------------------------------------------------
`include "irrigation_light_controller_macros.svh"

module ilc_pump_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ilc_pkg::pipe_ctrl_t           ctrl,
  input  ilc_pkg::s2_t                  s2_i,
  input  ilc_pkg::cfg_t                 cfg_i,
  output logic [ilc_pkg::LEVEL_W-1:0]   light_level_o,
  output logic                          pump_on_o,
  output logic [ilc_pkg::PCT_W-1:0]     moisture_o
);

  logic                      pump_running_r, pump_running_nxt;
  logic [ilc_pkg::NOW_W-1:0] last_start_r,   last_start_nxt;
  logic [ilc_pkg::NOW_W-1:0] last_stop_r,    last_stop_nxt;
  logic [ilc_pkg::LEVEL_W-1:0] light_r,      light_nxt;
  logic [ilc_pkg::PCT_W-1:0] moist_r;

  // 33-bit time compares, no wrap
  logic [ilc_pkg::NOW_W:0] now_ext;
  logic [ilc_pkg::NOW_W:0] pause_end;
  logic [ilc_pkg::NOW_W:0] run_end;
  logic                    start;
  logic                    run1;
  logic                    stop;

  assign now_ext   = {1'b0, s2_i.now};
  assign pause_end = {1'b0, last_stop_r}  + 33'(cfg_i.watering_pause);
  assign run_end   = {1'b0, last_start_r} + 33'(cfg_i.watering_duration);

  // A start in this tick sets last start to now, so the run-time limit cannot fire
  assign start = (s2_i.moisture < cfg_i.min_moisture) && !pump_running_r &&
                 (now_ext > pause_end);
  assign run1  = pump_running_r || start;
  assign stop  = run1 && ((s2_i.moisture > cfg_i.target_moisture) ||
                          (!start && (now_ext > run_end)));

  // Next pump state
  always_comb begin
    pump_running_nxt = pump_running_r;
    last_start_nxt   = last_start_r;
    last_stop_nxt    = last_stop_r;
    if (!cfg_i.enable || !s2_i.reservoir_ok) begin
      pump_running_nxt = 1'b0;
      last_stop_nxt    = s2_i.now;
    end else begin
      pump_running_nxt = run1 && !stop;
      if (start) begin
        last_start_nxt = s2_i.now;
      end
      if (stop) begin
        last_stop_nxt = s2_i.now;
      end
    end
  end

  // Light level
  assign light_nxt = (cfg_i.enable && s2_i.daytime) ? cfg_i.light_intensity : '0;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pump_running_r <= 1'b0;
      last_start_r   <= '0;
      last_stop_r    <= '0;
    end else if (ctrl.load_out) begin
      pump_running_r <= pump_running_nxt;
      last_start_r   <= last_start_nxt;
      last_stop_r    <= last_stop_nxt;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      light_r <= light_nxt;
      moist_r <= s2_i.moisture;
    end
  end

  assign light_level_o = light_r;
  assign pump_on_o     = pump_running_r;
  assign moisture_o    = moist_r;

  // Checks
  `ILC_ASSERT_NXT(a_disable_off, clk, rst_n, ctrl.load_out && !cfg_i.enable, !pump_running_r && light_r == '0, "disabled tick left pump or light on")
  `ILC_ASSERT_NXT(a_tank_low, clk, rst_n, ctrl.load_out && !s2_i.reservoir_ok, !pump_running_r && last_stop_r == $past(s2_i.now), "low reservoir did not stop pump")
  `ILC_ASSERT_IMP(a_start_dry, clk, rst_n, $rose(pump_running_r), $past(s2_i.moisture < cfg_i.min_moisture), "pump started without dry soil")

endmodule

### rtl/irrigation_light_controller.sv
// ---------------------------------------------------------------------------
// Irrigation light controller
// Pipeline: input register, quotient multiply, remainder, result register.
// Throughput: one tick per cycle while out_ch is ready; the pump state
//   updates as a tick enters the result register, so consecutive ticks
//   see each other's state.
// Reset: registers return to defaults, pump off, times zero, pipeline empty.
// ---------------------------------------------------------------------------
module irrigation_light_controller (
  input  logic      clk,
  input  logic      rst_n,
  ilc_in_if.sink    in_ch,
  ilc_out_if.source out_ch,
  ilc_cfg_if.sink   cfg_ch
);

  // Register file
  ilc_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (ilc_pkg::cfg_idx_t'(cfg_ch.index))
        ilc_pkg::CFG_ENABLE:            cfg_nxt.enable            = cfg_ch.data[0];
        ilc_pkg::CFG_MIN_MOISTURE:      cfg_nxt.min_moisture      = cfg_ch.data[6:0];
        ilc_pkg::CFG_TARGET_MOISTURE:   cfg_nxt.target_moisture   = cfg_ch.data[6:0];
        ilc_pkg::CFG_WATERING_DURATION: cfg_nxt.watering_duration = cfg_ch.data[7:0];
        ilc_pkg::CFG_WATERING_PAUSE:    cfg_nxt.watering_pause    = cfg_ch.data[7:0];
        ilc_pkg::CFG_LIGHT_INTENSITY:   cfg_nxt.light_intensity   = cfg_ch.data[7:0];
        ilc_pkg::CFG_SUNRISE_SECOND:    cfg_nxt.sunrise_second    = cfg_ch.data[16:0];
        ilc_pkg::CFG_SUNSET_SECOND:     cfg_nxt.sunset_second     = cfg_ch.data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ilc_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipeline occupancy; a stage moves when the one after it is free or moving
  logic v_in_r, v_s1_r, v_s2_r, v_out_r;
  logic v_in_nxt, v_s1_nxt, v_s2_nxt, v_out_nxt;
  logic rdy_in, rdy_s1, rdy_s2, rdy_out;
  ilc_pkg::pipe_ctrl_t ctrl;

  assign rdy_out = !v_out_r || out_ch.ready;
  assign rdy_s2  = !v_s2_r  || rdy_out;
  assign rdy_s1  = !v_s1_r  || rdy_s2;
  assign rdy_in  = !v_in_r  || rdy_s1;

  assign ctrl.load_in  = in_ch.valid && rdy_in;
  assign ctrl.load_s1  = v_in_r && rdy_s1;
  assign ctrl.load_s2  = v_s1_r && rdy_s2;
  assign ctrl.load_out = v_s2_r && rdy_out;

  assign v_in_nxt  = ctrl.load_in  || (v_in_r && !ctrl.load_s1);
  assign v_s1_nxt  = ctrl.load_s1  || (v_s1_r && !ctrl.load_s2);
  assign v_s2_nxt  = ctrl.load_s2  || (v_s2_r && !ctrl.load_out);
  assign v_out_nxt = ctrl.load_out || (v_out_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_in_r  <= 1'b0;
      v_s1_r  <= 1'b0;
      v_s2_r  <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      v_in_r  <= v_in_nxt;
      v_s1_r  <= v_s1_nxt;
      v_s2_r  <= v_s2_nxt;
      v_out_r <= v_out_nxt;
    end
  end

  assign in_ch.ready  = rdy_in;
  assign out_ch.valid = v_out_r;

  // Datapath
  ilc_pkg::s2_t s2;

  ilc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .now_i     (in_ch.now_seconds),
    .raw_i     (in_ch.moisture_raw),
    .ok_i      (in_ch.reservoir_ok),
    .sunrise_i (cfg_r.sunrise_second),
    .sunset_i  (cfg_r.sunset_second),
    .s2_o      (s2)
  );

  ilc_pump_ctrl u_pump (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .s2_i          (s2),
    .cfg_i         (cfg_r),
    .light_level_o (out_ch.light_level),
    .pump_on_o     (out_ch.pump_on),
    .moisture_o    (out_ch.moisture_percent)
  );

endmodule
